// ===== src/huffman_stream_decoder_core_assert.svh =====
// Assertion macros used by the decoder state machine (hsd_ctrl).
`ifndef HUFFMAN_STREAM_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_STREAM_DECODER_CORE_ASSERT_SVH
// Condition a must imply condition b in the same cycle.
`define HSD_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("decoder check failed");
// Condition a must imply condition b in the following cycle.
`define HSD_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("decoder check failed");
`endif

// ===== src/hsd_pkg.sv =====
// Shared types and constants for the Huffman stream decoder.
`default_nettype none
package hsd_pkg;
  localparam int MaxCodeBitsDef  = 32;
  localparam int TableEntriesDef = 256;
  localparam int CodeW    = 32;
  localparam int PrefLenW = 6;
  localparam int BufDepth = 8;

  typedef enum logic [2:0] {
    PH_PAD, PH_COUNT, PH_SYM, PH_LEN, PH_CODE, PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_RD, S_CMP, S_CHK, S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] compressed_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       run_last;
    logic       stream_end;
    logic       code_overflow;
  } out_word_t;

  typedef struct packed {
    logic [7:0]       sym;
    logic [7:0]       len;
    logic [CodeW-1:0] code;
  } entry_t;

  typedef struct packed {
    logic load;
    logic hdr_bit;
    logic skip_bit;
    logic data_bit;
    logic scan_next;
    logic hit;
    logic miss_end;
    logic emit_adv;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic in_data;
    logic skip;
    logic pos_last;
    logic fill_zero;
    logic match;
    logic scan_last;
    logic nres_zero;
    logic run_last;
    logic last;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/hsd_ctrl.sv =====
// Sequencing state machine of the decoder.
`default_nettype none
module hsd_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        comp_valid,
  output logic             comp_stall,
  output logic             res_valid,
  input  wire logic        res_stall,
  input  wire hsd_pkg::sts_t sts,
  output hsd_pkg::cmd_t    cmd
);
  import hsd_pkg::*;
  `include "huffman_stream_decoder_core_assert.svh"

  state_t state, state_next;
  state_t end_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    end_dst = (!sts.nres_zero || sts.last) ? S_EMIT : S_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (comp_valid) state_next = S_BIT;
      end
      S_BIT: begin
        if (sts.skip || !sts.in_data) begin
          state_next = sts.pos_last ? end_dst : S_BIT;
        end else begin
          state_next = sts.fill_zero ? S_CHK : S_RD;
        end
      end
      S_RD: state_next = S_CMP;
      S_CMP: begin
        if (sts.match) begin
          state_next = sts.pos_last ? S_EMIT : S_BIT;
        end else if (sts.scan_last) begin
          state_next = sts.pos_last ? end_dst : S_BIT;
        end else begin
          state_next = S_RD;
        end
      end
      S_CHK: state_next = sts.pos_last ? end_dst : S_BIT;
      S_EMIT: begin
        if (!res_stall && sts.run_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    comp_stall = 1'b1;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        comp_stall = 1'b0;
        cmd.load = comp_valid;
      end
      S_BIT: begin
        if (sts.skip) cmd.skip_bit = 1'b1;
        else if (!sts.in_data) cmd.hdr_bit = 1'b1;
        else cmd.data_bit = 1'b1;
      end
      S_RD: ;
      S_CMP: begin
        if (sts.match) cmd.hit = 1'b1;
        else if (sts.scan_last) cmd.miss_end = 1'b1;
        else cmd.scan_next = 1'b1;
      end
      S_CHK: cmd.miss_end = 1'b1;
      S_EMIT: begin
        res_valid = 1'b1;
        cmd.emit_adv = !res_stall;
        cmd.restart = !res_stall && sts.run_last && sts.last;
      end
      default: ;
    endcase
  end

  `HSD_ASSERT_NEXT(a_rd_then_cmp, state == S_RD, state == S_CMP)
  `HSD_ASSERT_NEXT(a_load_starts, cmd.load, state == S_BIT)
  `HSD_ASSERT_NEXT(a_emit_done, state == S_EMIT && !res_stall && sts.run_last, state == S_IDLE)
  `HSD_ASSERT_NOW(a_emit_has_work, state == S_EMIT, !sts.nres_zero || sts.last)
endmodule
`default_nettype wire

// ===== src/hsd_dp.sv =====
// Bit parser, code table and result buffer of the decoder.
`default_nettype none
module hsd_dp #(
  parameter int MAX_CODE_BITS = hsd_pkg::MaxCodeBitsDef,
  parameter int TABLE_ENTRIES = hsd_pkg::TableEntriesDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hsd_pkg::in_word_t comp_word,
  input  wire hsd_pkg::cmd_t     cmd,
  output hsd_pkg::sts_t          sts,
  output hsd_pkg::out_word_t     res_word
);
  import hsd_pkg::*;

  localparam int CodeLimit = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FillW = $clog2(TABLE_ENTRIES + 1);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [2:0] pos, pos_next;
  logic [3:0] nres, nres_next;
  logic [2:0] out_idx, out_idx_next;
  logic [7:0] sbuf [BufDepth];
  phase_t phase, phase_next;
  logic [7:0] fbc, fbc_next;
  logic [2:0] pad, pad_next;
  logic [8:0] ent, ent_next;
  logic [FillW-1:0] fill, fill_next;
  logic [7:0] psym, psym_next;
  logic [7:0] plenp, plenp_next;
  logic [CodeW-1:0] pcode, pcode_next;
  logic [CodeW-1:0] pbits, pbits_next;
  logic [PrefLenW-1:0] plen, plen_next;
  logic ovf, ovf_next;
  logic [AddrW-1:0] scan_idx, scan_idx_next;
  logic b;
  logic we;
  entry_t wdata;
  logic do_store;
  logic [7:0] lnew, snew, sbase;
  logic [CodeW-1:0] cnew;
  logic [8:0] ent_dec;
  logic [3:0] nres_tot;

  assign b = byte_q[pos];

  always_comb begin
    pos_next = pos; nres_next = nres; out_idx_next = out_idx;
    phase_next = phase; fbc_next = fbc; pad_next = pad; ent_next = ent;
    fill_next = fill; psym_next = psym; plenp_next = plenp; pcode_next = pcode;
    pbits_next = pbits; plen_next = plen; ovf_next = ovf; scan_idx_next = scan_idx;
    we = 1'b0; do_store = 1'b0;
    wdata = '{sym: psym, len: plenp, code: pcode};
    lnew = plenp | (8'(b) << fbc[2:0]);
    sbase = (fbc == 8'd0) ? 8'd0 : psym;
    snew = sbase | (8'(b) << fbc[2:0]);
    cnew = {pcode[CodeW-2:0], b};
    ent_dec = ent - 9'd1;
    if (cmd.load) begin
      pos_next = '0; nres_next = '0; out_idx_next = '0;
    end
    if (cmd.hdr_bit) begin
      pos_next = pos + 3'd1;
      fbc_next = fbc + 8'd1;
      unique case (phase)
        PH_PAD: begin
          pad_next = {pad[1:0], b};
          if (fbc == 8'd2) begin
            fbc_next = '0; ent_next = '0; phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          ent_next = ent | (9'(b) << fbc[2:0]);
          if (fbc == 8'd7) begin
            fbc_next = '0;
            ent_next = (ent | (9'(b) << fbc[2:0])) + 9'd1;
            psym_next = '0;
            phase_next = PH_SYM;
          end
        end
        PH_SYM: begin
          psym_next = snew;
          if (fbc == 8'd7) begin
            fbc_next = '0; plenp_next = '0; phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          plenp_next = lnew;
          if (fbc == 8'd7) begin
            fbc_next = '0;
            pcode_next = '0;
            if (lnew > 8'(CodeLimit)) ovf_next = 1'b1;
            if (lnew == 8'd0) begin
              do_store = 1'b1;
              wdata = '{sym: psym, len: lnew, code: '0};
            end else begin
              phase_next = PH_CODE;
            end
          end
        end
        PH_CODE: begin
          pcode_next = cnew;
          if (fbc + 8'd1 == plenp) begin
            do_store = 1'b1;
            wdata = '{sym: psym, len: plenp, code: cnew};
          end
        end
        default: ;
      endcase
      if (do_store) begin
        if (fill < FillW'(TABLE_ENTRIES)) begin
          we = 1'b1;
          fill_next = fill + FillW'(1);
        end
        pcode_next = '0;
        fbc_next = '0;
        ent_next = ent_dec;
        phase_next = (ent_dec == 9'd0) ? PH_DATA : PH_SYM;
      end
    end
    if (cmd.skip_bit) pos_next = pos + 3'd1;
    if (cmd.data_bit) begin
      pbits_next = {pbits[CodeW-2:0], b};
      plen_next = plen + PrefLenW'(1);
      scan_idx_next = '0;
    end
    if (cmd.scan_next) scan_idx_next = scan_idx + AddrW'(1);
    if (cmd.hit) begin
      nres_next = nres + 4'd1;
      pbits_next = '0; plen_next = '0;
      pos_next = pos + 3'd1;
    end
    if (cmd.miss_end) begin
      if (plen >= PrefLenW'(CodeLimit)) begin
        ovf_next = 1'b1; pbits_next = '0; plen_next = '0;
      end
      pos_next = pos + 3'd1;
    end
    if (cmd.emit_adv) out_idx_next = out_idx + 3'd1;
    if (cmd.restart) begin
      phase_next = PH_PAD; fbc_next = '0; pad_next = '0; ent_next = '0;
      fill_next = '0; psym_next = '0; plenp_next = '0; pcode_next = '0;
      pbits_next = '0; plen_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; nres <= '0; out_idx <= '0;
      phase <= PH_PAD; fbc <= '0; pad <= '0; ent <= '0; fill <= '0;
      psym <= '0; plenp <= '0; pcode <= '0; pbits <= '0; plen <= '0; ovf <= 1'b0;
    end else begin
      pos <= pos_next; nres <= nres_next; out_idx <= out_idx_next;
      phase <= phase_next; fbc <= fbc_next; pad <= pad_next; ent <= ent_next;
      fill <= fill_next; psym <= psym_next; plenp <= plenp_next;
      pcode <= pcode_next; pbits <= pbits_next; plen <= plen_next; ovf <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (cmd.load) begin
      byte_q <= comp_word.compressed_byte;
      last_q <= comp_word.final_byte;
    end
    if (cmd.hit) sbuf[nres[2:0]] <= rd_q.sym;
  end

  always_ff @(posedge clk) begin
    if (we) mem[fill[AddrW-1:0]] <= wdata;
    rd_q <= mem[scan_idx];
  end

  assign nres_tot = (nres == 4'd0) ? 4'd1 : nres;

  always_comb begin
    sts.in_data   = (phase == PH_DATA);
    sts.skip      = last_q && (phase == PH_DATA) && ({1'b0, pos} >= 4'd8 - {1'b0, pad});
    sts.pos_last  = (pos == 3'd7);
    sts.fill_zero = (fill == '0);
    sts.match     = (rd_q.len == {2'b00, plen}) && (rd_q.code == pbits);
    sts.scan_last = (FillW'(scan_idx) == fill - FillW'(1));
    sts.nres_zero = (nres == 4'd0);
    sts.run_last  = ({1'b0, out_idx} == nres_tot - 4'd1);
    sts.last      = last_q;
  end

  always_comb begin
    res_word.symbol        = (nres == 4'd0) ? 8'd0 : sbuf[out_idx];
    res_word.symbol_valid  = (nres != 4'd0);
    res_word.run_last      = sts.run_last;
    res_word.stream_end    = last_q && sts.run_last;
    res_word.code_overflow = ovf;
  end
endmodule
`default_nettype wire

// ===== src/huffman_stream_decoder_core.sv =====
// Top level of the Huffman stream decoder with an in-band code table.
// Each accepted byte is unpacked least significant bit first, one bit at a
// time. Header bits (padding, entry count, symbol, length, code bits) fill
// the code table. Each data bit is followed by one check step when the
// table is still empty, or by a read step and a compare step per table
// entry compared: the table memory has one read port, so the prefix is
// checked against entries in ascending order and the scan stops at the
// first match. Result words are then delivered one at a time, held while
// the output is stalled. One byte is worked at a time; the input stalls
// until all result words of the byte have been taken. A non-final byte
// that decodes nothing yields no word; the final byte always yields at
// least one, and after it the table is emptied and a new stream with a
// fresh header may follow. The overflow flag stays set until reset.
`default_nettype none
module huffman_stream_decoder_core #(
  parameter int MAX_CODE_BITS = hsd_pkg::MaxCodeBitsDef,
  parameter int TABLE_ENTRIES = hsd_pkg::TableEntriesDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               comp_valid,
  output logic                    comp_stall,
  input  wire hsd_pkg::in_word_t  comp_word,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output hsd_pkg::out_word_t      res_word
);
  import hsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks bits, table scan and result delivery.
  hsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .comp_valid (comp_valid),
    .comp_stall (comp_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: header parser, code table, prefix and result buffer.
  hsd_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .comp_word (comp_word),
    .cmd       (cmd),
    .sts       (sts),
    .res_word  (res_word)
  );
endmodule
`default_nettype wire

// ===== dv/tb_huffman_stream_decoder_core.sv =====
// Self-checking testbench for the Huffman stream decoder core.
`timescale 1ns / 1ps
`default_nettype none
module tb_huffman_stream_decoder_core;
  import hsd_pkg::*;

  localparam int CodeLimit = 32;
  localparam int TableDepth = 256;
  localparam int CycleLimit = 3000000;

  // Decoder model: mirrors the block's parse state and table, and keeps the
  // queue of result words still owed by the block.
  class symbol_scoreboard;
    phase_t      phase;
    int unsigned fcount;
    bit [2:0]    pad;
    int unsigned left;
    int unsigned fill;
    bit [7:0]    psym;
    bit [7:0]    plen;
    bit [31:0]   pcode;
    bit [7:0]    tsym [TableDepth];
    bit [7:0]    tlen [TableDepth];
    bit [31:0]   tcode [TableDepth];
    bit [31:0]   prefix;
    int unsigned plength;
    bit          ovf;
    out_word_t   owed [$];
    int          errors;

    function void restart();
      phase = PH_PAD; fcount = 0; pad = 0; left = 0; fill = 0;
      psym = 0; plen = 0; pcode = 0; prefix = 0; plength = 0;
    endfunction

    function void clear();
      restart();
      ovf = 0; errors = 0; owed.delete();
    endfunction

    function void store();
      if (fill < TableDepth) begin
        tsym[fill] = psym; tlen[fill] = plen; tcode[fill] = pcode;
        fill++;
      end
      pcode = 0; fcount = 0; left = left - 1;
      phase = (left == 0) ? PH_DATA : PH_SYM;
    endfunction

    // Consume one stream bit; return 1 with sym set on a decoded symbol.
    function bit shift_bit(bit b, output bit [7:0] sym);
      sym = 0;
      case (phase)
        PH_PAD: begin
          pad = {pad[1:0], b};
          if (++fcount == 3) begin
            fcount = 0; left = 0; phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          left = left | (int'(b) << fcount);
          if (++fcount == 8) begin
            fcount = 0; left = left + 1; psym = 0; phase = PH_SYM;
          end
        end
        PH_SYM: begin
          if (fcount == 0) psym = 0;
          psym[fcount] = b;
          if (++fcount == 8) begin
            fcount = 0; plen = 0; phase = PH_LEN;
          end
        end
        PH_LEN: begin
          plen[fcount] = b;
          if (++fcount == 8) begin
            fcount = 0; pcode = 0;
            if (plen > CodeLimit) ovf = 1;
            if (plen == 0) store();
            else phase = PH_CODE;
          end
        end
        PH_CODE: begin
          pcode = {pcode[30:0], b};
          if (++fcount == plen) store();
        end
        default: begin
          prefix = {prefix[30:0], b};
          plength++;
          for (int i = 0; i < fill; i++) begin
            if (tlen[i] == plength && tcode[i] == prefix) begin
              sym = tsym[i]; prefix = 0; plength = 0;
              return 1;
            end
          end
          if (plength >= CodeLimit) begin
            ovf = 1; prefix = 0; plength = 0;
          end
        end
      endcase
      return 0;
    endfunction

    // Note an accepted input word and queue the result words it causes.
    function void note_byte(in_word_t w);
      out_word_t res [$];
      out_word_t r;
      bit [7:0]  s;
      for (int p = 0; p < 8; p++) begin
        if (w.final_byte && phase == PH_DATA && p >= 8 - pad) continue;
        if (shift_bit(w.compressed_byte[p], s)) begin
          r = '0; r.symbol = s; r.symbol_valid = 1;
          res = {res, r};
        end
      end
      if (w.final_byte && res.size() == 0) res = {res, out_word_t'('0)};
      foreach (res[k]) begin
        res[k].run_last = (k == res.size() - 1);
        res[k].stream_end = w.final_byte && (k == res.size() - 1);
        res[k].code_overflow = ovf;
        owed = {owed, res[k]};
      end
      if (w.final_byte) restart();
    endfunction

    // Check one accepted result word against the oldest owed word.
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word, got %h", $time, got);
        errors++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.symbol !== exp_w.symbol)
        $display("%0t: symbol expected %h got %h", $time, exp_w.symbol, got.symbol);
      if (got.symbol_valid !== exp_w.symbol_valid)
        $display("%0t: symbol_valid expected %b got %b", $time,
                 exp_w.symbol_valid, got.symbol_valid);
      if (got.run_last !== exp_w.run_last)
        $display("%0t: run_last expected %b got %b", $time, exp_w.run_last, got.run_last);
      if (got.stream_end !== exp_w.stream_end)
        $display("%0t: stream_end expected %b got %b", $time,
                 exp_w.stream_end, got.stream_end);
      if (got.code_overflow !== exp_w.code_overflow)
        $display("%0t: code_overflow expected %b got %b", $time,
                 exp_w.code_overflow, got.code_overflow);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      comp_valid = 0;
  logic      comp_stall;
  in_word_t  comp_word = '0;
  logic      res_valid;
  logic      res_stall = 0;
  out_word_t res_word;

  symbol_scoreboard board = new();
  int unsigned      cycles = 0;
  bit               calm = 0;   // no idling on either side while set

  // Bit stream being packed into bytes for the stream in progress.
  bit               bits [$];

  huffman_stream_decoder_core DUT (
    .clk(clk), .rst(rst),
    .comp_valid(comp_valid), .comp_stall(comp_stall), .comp_word(comp_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Count cycles and give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** huffman_stream_decoder_core: FAILED **");
      $finish;
    end
  end

  // Result side: check each accepted word, stall at random.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_word(res_word);
    res_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
  end

  // Drive one word and hold it until the block takes it; idle at random first.
  // Drop valid after the accept and wait with it low before the next word.
  task automatic send_word(input bit [7:0] b, input bit fin);
    while (!calm && $urandom_range(99) < 12) begin
      comp_valid <= 0;
      @(posedge clk);
    end
    comp_valid <= 1;
    comp_word  <= '{compressed_byte: b, final_byte: fin};
    @(posedge clk);
    while (comp_stall) @(posedge clk);
    board.note_byte('{compressed_byte: b, final_byte: fin});
    comp_valid <= 0;
    @(posedge clk);
  endtask

  // Add a field LSB first or MSB first to the bit stream.
  task automatic put_lsb(input int v, input int n);
    for (int i = 0; i < n; i++) bits = {bits, v[i]};
  endtask

  task automatic put_msb(input bit [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bits = {bits, v[i]};
  endtask

  // Flush the bit stream as bytes; the final byte carries padding bits.
  task automatic flush_stream(input int padn);
    bit [7:0] b;
    int       k;
    for (int i = 0; i < padn; i++) bits = {bits, 1'($urandom_range(1))};
    while (bits.size() % 8 != 0) bits = {bits, 1'($urandom_range(1))};
    k = bits.size() / 8;
    for (int j = 0; j < k; j++) begin
      for (int i = 0; i < 8; i++) b[i] = bits.pop_front();
      send_word(b, j == k - 1);
    end
  endtask

  // Build a prefix-free table of n codes and some data symbols into the bit
  // stream of one stream. Padding covers the spare bits so the final data bits match.
  task automatic send_stream(input int n, input int nsym, input bit junk_len);
    bit [31:0] code [$];
    int        len  [$];
    int        used, padn, ci;
    // Codes: i ones followed by a zero, last one all ones (prefix-free).
    for (int i = 0; i < n; i++) begin
      len = {len, (i == n - 1) ? n - 1 : i + 1};
      code = {code, (i == n - 1) ? (32'h1 << (n - 1)) - 1 : ((32'h1 << (i + 1)) - 2)};
    end
    if (n == 1) len[0] = 1;
    put_msb(0, 3);
    put_lsb(n - 1 + (junk_len ? 1 : 0), 8);
    for (int i = 0; i < n; i++) begin
      put_lsb($urandom_range(255), 8);
      put_lsb(len[i], 8);
      put_msb(code[i], len[i]);
    end
    if (junk_len) begin
      // Oversized or zero length entry: stored but never matches.
      put_lsb($urandom_range(255), 8);
      if ($urandom_range(1)) begin
        put_lsb(33 + $urandom_range(3), 8); put_msb($urandom, 32); put_msb($urandom, 4);
      end else put_lsb(0, 8);
    end
    for (int s = 0; s < nsym; s++) begin
      ci = $urandom_range(n - 1);
      put_msb(code[ci], len[ci]);
    end
    // Patch the padding field at the head to match the spare bits.
    used = bits.size() % 8;
    padn = (used == 0) ? 0 : 8 - used;
    if (padn > 7) padn = 7;
    bits[0] = padn[2]; bits[1] = padn[1]; bits[2] = padn[0];
    while (bits.size() % 8 != 0) bits = {bits, 1'($urandom_range(1))};
  endtask

  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_stream(input int n, input int nsym, input bit junk);
    bits.delete();
    send_stream(n, nsym, junk);
    flush_stream(0);
  endtask

  initial begin
    int items;
    board.clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: smallest table, zero/oversized lengths, noise bytes,
    // a lone final byte, a stray prefix reaching the code limit.
    run_stream(1, 6, 0);
    run_stream(2, 10, 1);
    send_word(8'h00, 1);
    send_word(8'hFF, 1);
    send_word(8'hFF, 0); send_word(8'h00, 0); send_word(8'hA5, 0);
    for (int i = 0; i < 6; i++) send_word(8'hFF, 0);
    send_word(8'h5A, 1);
    drain();
    // A four-entry table with a junk entry, then pause until everything owed has come back.
    run_stream(4, 12, 1);
    drain();

    // Random: mostly well-formed streams, some raw noise streams.
    items = 0;
    while (items < 360) begin
      calm = (items > 120 && items < 180);
      if ($urandom_range(9) < 8) begin
        bits.delete();
        send_stream(1 + $urandom_range(7), 1 + $urandom_range(20), $urandom_range(4) == 0);
        items += bits.size() / 8;
        flush_stream(0);
      end else begin
        for (int j = $urandom_range(1, 5); j > 0; j--) begin
          send_word(8'($urandom_range(255)), j == 1);
          items++;
        end
      end
    end
    // A large table once, to reach the long comparison scan.
    run_stream(20, 10, 0);
    calm = 0;
    drain();
    if (board.errors == 0 && board.owed.size() == 0)
      $display("** huffman_stream_decoder_core: PASSED **");
    else
      $display("** huffman_stream_decoder_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
